// ===== rtl/svpwm_compare_and_sample_point_core_defines.svh =====
// Assertion macros used by the checker file of the SVPWM core.
`ifndef SVPWM_COMPARE_AND_SAMPLE_POINT_CORE_DEFINES_SVH
`define SVPWM_COMPARE_AND_SAMPLE_POINT_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SVPWM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svpwm check failed");

// Next-cycle implication, checked during reset as well.
`define SVPWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("svpwm check failed");

`endif

// ===== rtl/svpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// svpwm_pkg
// Types and constants of the space vector PWM compare and sample point core.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned DivSteps = 24;

  localparam logic [CfgIdxW-1:0] REG_GAIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PERIOD = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SAMPLE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DEAD   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_NOISE  = 3'd4;

  localparam logic [23:0] GAIN_RST   = 24'd147802;
  localparam logic [15:0] PERIOD_RST = 16'd4000;
  localparam logic [15:0] SAMPLE_RST = 16'd80;
  localparam logic [15:0] DEAD_RST   = 16'd40;
  localparam logic [15:0] NOISE_RST  = 16'd40;

  // sqrt(3)/2 in Q0.16.
  localparam logic [16:0] SQRT3_2_Q16 = 17'd56756;

  localparam logic [2:0] SEC_ZERO = 3'd0;
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;
  localparam logic [2:0] SEC_6 = 3'd6;

  localparam logic [1:0] BAND_LOW  = 2'd0;
  localparam logic [1:0] BAND_MED  = 2'd1;
  localparam logic [1:0] BAND_HIGH = 2'd2;

  // One beat inside the scaling divider.
  typedef struct packed {
    logic [2:0]  sector;
    logic [32:0] t1a;
    logic [32:0] t2a;
    logic [33:0] sum;
    logic [35:0] r;
    logic [24:0] q;
  } dstage_t;

endpackage

// ===== rtl/svpwm_compare_and_sample_point_core.sv =====
// ----------------------------------------------------------------------------
// svpwm_compare_and_sample_point_core
// Seven-segment SVPWM: compare values, sector and ADC sample point per beat.
// ----------------------------------------------------------------------------
// Each beat passes stage 1, stage 2, stage 3, the divider, stage 4 and stage 5 in order.
// Throughput: one beat per cycle, but a stalled output freezes the whole pipeline;
// nothing is lost or repeated. The 24-stage scaling divider sets the depth.
// Reset clears all valid bits and loads the configuration reset values.
module svpwm_compare_and_sample_point_core #(
  parameter int TICK_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [svpwm_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [svpwm_pkg::CfgDataW-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [15:0]                volt_alpha,
  input  logic signed [15:0]                volt_beta,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [15:0]                       compare_u,
  output logic [15:0]                       compare_v,
  output logic [15:0]                       compare_w,
  output logic [2:0]                        sector,
  output logic [15:0]                       sample_point,
  output logic [1:0]                        band,
  output logic                              scaled
);
  import svpwm_pkg::*;

  localparam logic [15:0] TMASK = (TICK_WIDTH >= 16) ? 16'hFFFF
                                  : 16'((32'd1 << TICK_WIDTH) - 32'd1);

  logic [23:0] gain;
  logic [15:0] period_ticks, sample_ticks, dead_ticks, noise_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain         <= GAIN_RST;
      period_ticks <= PERIOD_RST;
      sample_ticks <= SAMPLE_RST;
      dead_ticks   <= DEAD_RST;
      noise_ticks  <= NOISE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN:   gain         <= cfg_data;
        REG_PERIOD: period_ticks <= cfg_data[15:0];
        REG_SAMPLE: sample_ticks <= cfg_data[15:0];
        REG_DEAD:   dead_ticks   <= cfg_data[15:0];
        REG_NOISE:  noise_ticks  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [23:0] pq;
  assign pq = {period_ticks, 8'd0};

  logic adv;
  assign adv = ~out_valid | out_ready;
  assign in_ready = adv;

  // Stage 1: voltages, sector code and the two nonnegative operands.
  logic signed [34:0] u1, u2, u3;
  logic [2:0]  code, sec1_next;
  logic signed [34:0] o1, o2;
  logic [32:0] op1_next, op2_next;

  always_comb begin
    u1 = 35'(volt_beta) <<< 16;
    u2 = $signed({18'd0, SQRT3_2_Q16}) * 35'(volt_alpha) - (35'(volt_beta) <<< 15);
    u3 = -u2 - u1;
    code = {u3 > 0, u2 > 0, u1 > 0};
    case (code)
      3'd3: begin sec1_next = SEC_1; o1 = u1;  o2 = u2;  end
      3'd1: begin sec1_next = SEC_2; o1 = -u3; o2 = -u2; end
      3'd5: begin sec1_next = SEC_3; o1 = u3;  o2 = u1;  end
      3'd4: begin sec1_next = SEC_4; o1 = -u2; o2 = -u1; end
      3'd6: begin sec1_next = SEC_5; o1 = u2;  o2 = u3;  end
      3'd2: begin sec1_next = SEC_6; o1 = -u1; o2 = -u3; end
      default: begin sec1_next = SEC_ZERO; o1 = '0; o2 = '0; end
    endcase
    op1_next = (o1 > 0) ? o1[32:0] : '0;
    op2_next = (o2 > 0) ? o2[32:0] : '0;
  end

  logic        v1;
  logic [2:0]  sec1;
  logic [32:0] op1, op2;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
    if (adv) begin
      sec1 <= sec1_next;
      op1  <= op1_next;
      op2  <= op2_next;
    end
  end

  // Stage 2: gain times operand, split into two partial products each.
  logic        v2;
  logic [2:0]  sec2;
  logic [40:0] p1l, p2l;
  logic [39:0] p1h, p2h;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      sec2 <= sec1;
      p1l  <= gain * op1[16:0];
      p1h  <= gain * op1[32:17];
      p2l  <= gain * op2[16:0];
      p2h  <= gain * op2[32:17];
    end
  end

  // Stage 3: assemble the products and cut them to Q.8 ticks.
  logic [56:0] f1, f2;
  dstage_t     d0_next;

  always_comb begin
    f1 = {p1h, 17'd0} + 57'(p1l);
    f2 = {p2h, 17'd0} + 57'(p2l);
    d0_next.sector = sec2;
    d0_next.t1a    = f1[56:24];
    d0_next.t2a    = f2[56:24];
    d0_next.sum    = 34'(f1[56:24]) + 34'(f2[56:24]);
    d0_next.r      = '0;
    d0_next.q      = '0;
  end

  dstage_t d   [0:DivSteps];
  logic    dv  [0:DivSteps];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (adv) dv[0] <= v2;
    if (adv) d[0] <= d0_next;
  end

  // Divider: q = floor(t1a * pq / sum), one bit of pq per stage, MSB first.
  // The remainder stays below sum, so at most two subtractions per step.
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    localparam int BitPos = DivSteps - 1 - k;
    logic [35:0] rs;
    dstage_t     dn;

    always_comb begin
      dn = d[k];
      rs = {d[k].r[34:0], 1'b0} + (pq[BitPos] ? 36'(d[k].t1a) : 36'd0);
      if (rs >= {1'b0, d[k].sum, 1'b0}) begin
        dn.r = rs - {1'b0, d[k].sum, 1'b0};
        dn.q = {d[k].q[23:0], 1'b0} + 25'd2;
      end else if (rs >= 36'(d[k].sum)) begin
        dn.r = rs - 36'(d[k].sum);
        dn.q = {d[k].q[23:0], 1'b0} + 25'd1;
      end else begin
        dn.r = rs;
        dn.q = {d[k].q[23:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (adv) dv[k+1] <= dv[k];
      if (adv) d[k+1] <= dn;
    end
  end

  // Stage 4: times, centre-aligned placement and reference phase.
  dstage_t     dl;
  logic        ovf;
  logic [23:0] tt0, tt1, tt2;
  logic [22:0] h0;
  logic [24:0] e1, e2;
  logic [15:0] c0, c1, c2, cu_n, cv_n, cw_n, ref_n;

  always_comb begin
    dl  = d[DivSteps];
    ovf = dl.sum > 34'(pq);
    if (ovf) begin
      tt1 = dl.q[23:0];
      tt2 = pq - dl.q[23:0];
      tt0 = '0;
    end else begin
      tt1 = dl.t1a[23:0];
      tt2 = dl.t2a[23:0];
      tt0 = pq - dl.sum[23:0];
    end
    h0 = tt0[23:1];
    e1 = 25'(h0) + 25'(tt1);
    e2 = e1 + 25'(tt2);
    c0 = 16'(h0 >> 8) & TMASK;
    c1 = e1[23:8] & TMASK;
    c2 = e2[23:8] & TMASK;
    case (dl.sector)
      SEC_1: begin cu_n = c2; cv_n = c1; cw_n = c0; ref_n = cu_n; end
      SEC_2: begin cu_n = c1; cv_n = c2; cw_n = c0; ref_n = cv_n; end
      SEC_3: begin cu_n = c0; cv_n = c2; cw_n = c1; ref_n = cv_n; end
      SEC_4: begin cu_n = c0; cv_n = c1; cw_n = c2; ref_n = cw_n; end
      SEC_5: begin cu_n = c1; cv_n = c0; cw_n = c2; ref_n = cw_n; end
      SEC_6: begin cu_n = c2; cv_n = c0; cw_n = c1; ref_n = cu_n; end
      default: begin
        cu_n = c0; cv_n = c0; cw_n = c0;
        ref_n = {1'b0, period_ticks[15:1]} & TMASK;
      end
    endcase
  end

  logic        v4, sc4;
  logic [2:0]  sec4;
  logic [15:0] cu4, cv4, cw4, ref4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= dv[DivSteps];
    if (adv) begin
      sec4 <= dl.sector;
      sc4  <= ovf;
      cu4  <= cu_n;
      cv4  <= cv_n;
      cw4  <= cw_n;
      ref4 <= ref_n;
    end
  end

  // Stage 5: band choice and sample point into the output register.
  logic [16:0] dnt, ref2;
  logic [17:0] allt;
  logic [1:0]  band_n;
  logic [15:0] sp_n;

  always_comb begin
    dnt  = 17'(dead_ticks) + 17'(noise_ticks);
    allt = 18'(dnt) + 18'(sample_ticks);
    ref2 = {ref4, 1'b0};
    if (17'(ref4) > dnt) begin
      band_n = BAND_LOW;
      sp_n   = (ref4 > sample_ticks) ? ref4 - sample_ticks : '0;
    end else if (allt > 18'(ref2)) begin
      band_n = BAND_HIGH;
      sp_n   = (17'(ref4) > dnt) ? 16'(17'(ref4) - dnt) : '0;
    end else begin
      band_n = BAND_MED;
      sp_n   = (ref4 > sample_ticks) ? ref4 - sample_ticks : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= v4;
    if (adv) begin
      compare_u    <= cu4;
      compare_v    <= cv4;
      compare_w    <= cw4;
      sector       <= sec4;
      scaled       <= sc4;
      band         <= band_n;
      sample_point <= sp_n & TMASK;
    end
  end

endmodule

// ===== rtl/svpwm_chk.sv =====
// ----------------------------------------------------------------------------
// svpwm_chk
// Port-level checks of the SVPWM core, bound to its top level.
// ----------------------------------------------------------------------------
`include "svpwm_compare_and_sample_point_core_defines.svh"

module svpwm_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] compare_u,
  input logic [15:0] compare_v,
  input logic [15:0] compare_w,
  input logic [2:0]  sector,
  input logic [1:0]  band,
  input logic        scaled
);
  import svpwm_pkg::*;

  `SVPWM_ASSERT_NEXT(a_rst_clears, rst, !out_valid)
  `SVPWM_ASSERT_NEXT(a_out_hold, !rst && out_valid && !out_ready, rst || (out_valid && $stable(compare_u) && $stable(sector)))
  `SVPWM_ASSERT_NOW(a_zero_equal, out_valid && sector == SEC_ZERO, compare_u == compare_v && compare_v == compare_w && !scaled)
  `SVPWM_ASSERT_NOW(a_stall_ready, out_valid && !out_ready, !in_ready)
  `SVPWM_ASSERT_NOW(a_band_code, out_valid, band == BAND_LOW || band == BAND_MED || band == BAND_HIGH)

endmodule

bind svpwm_compare_and_sample_point_core svpwm_chk u_svpwm_chk (.*);

// ===== sim/svpwm_compare_and_sample_point_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// svpwm_compare_and_sample_point_core_test
// Self-checking bench for the SVPWM core. A short table of directed beats and
// a long run of random beats are predicted in the bench, while the sender
// idles in bursts and the receiver stalls, under several register settings.
// ----------------------------------------------------------------------------
module svpwm_compare_and_sample_point_core_test;
  import svpwm_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [15:0] cu;
    logic [15:0] cv;
    logic [15:0] cw;
    logic [2:0]  sec;
    logic [15:0] sp;
    logic [1:0]  bnd;
    logic        scl;
  } pwm_result_t;

  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic               exact;
    pwm_result_t        want;
  } vector_row_t;

  logic clk, rst, cfg_we, in_valid, in_ready, out_valid, scaled;
  logic out_ready = 1'b0;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic signed [15:0] volt_alpha, volt_beta;
  logic [15:0] compare_u, compare_v, compare_w, sample_point;
  logic [2:0] sector;
  logic [1:0] band;

  logic [23:0] m_gain;
  logic [15:0] m_period, m_sample, m_dead, m_noise;

  pwm_result_t pending_q[$];
  int errors = 0;
  int beats_out = 0;
  int scaled_seen = 0;
  int sector_seen[7];
  int band_seen[3];
  int ready_run = 0;
  logic ready_now = 1'b1;

  vector_row_t vectors[20] = '{
    '{16'sd0, 16'sd0, 1'b1, '{16'd2000, 16'd2000, 16'd2000, SEC_ZERO, 16'd1920,
      BAND_LOW, 1'b0}},
    '{16'sd32767, 16'sd0, 1'b0, '0}, '{-16'sd32768, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sd32767, 1'b0, '0}, '{16'sd0, -16'sd32768, 1'b0, '0},
    '{16'sd32767, 16'sd32767, 1'b0, '0}, '{-16'sd32768, -16'sd32768, 1'b0, '0},
    '{16'sd32767, -16'sd32768, 1'b0, '0}, '{-16'sd32768, 16'sd32767, 1'b0, '0},
    '{16'sd100, 16'sd10, 1'b0, '0}, '{16'sd10, 16'sd100, 1'b0, '0},
    '{-16'sd100, 16'sd10, 1'b0, '0}, '{-16'sd100, -16'sd10, 1'b0, '0},
    '{16'sd10, -16'sd100, 1'b0, '0}, '{16'sd100, -16'sd10, 1'b0, '0},
    '{16'sd1, 16'sd0, 1'b0, '0}, '{16'sd0, 16'sd1, 1'b0, '0},
    '{-16'sd1, 16'sd0, 1'b0, '0}, '{16'sd0, -16'sd1, 1'b0, '0},
    '{-16'sd1, -16'sd1, 1'b0, '0}
  };

  svpwm_compare_and_sample_point_core #(.TICK_WIDTH(16)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("** svpwm_compare_and_sample_point_core: FAILED **");
    $finish;
  end

  function automatic longint to_q8(longint p);
    return (p <= 0) ? 64'sd0 : (p >>> 24);
  endfunction

  function automatic longint sub_floor(longint x, longint y);
    return (x > y) ? x - y : 64'sd0;
  endfunction

  function automatic pwm_result_t predict_pwm(logic signed [15:0] a, logic signed [15:0] b);
    longint u1, u2, u3, px, py, pz, t1a, t2a, pq, t0, t1, t2, ref_ph, dn, sp;
    logic [2:0] code;
    pwm_result_t r;
    u1 = longint'(b) * 65536;
    u2 = 56756 * longint'(a) - 32768 * longint'(b);
    u3 = -u2 - u1;
    code = {u3 > 0, u2 > 0, u1 > 0};
    px = longint'(m_gain) * u1;
    py = longint'(m_gain) * u3;
    pz = longint'(m_gain) * u2;
    t1a = 0;
    t2a = 0;
    r = '0;
    case (code)
      3'd3: begin r.sec = SEC_1; t1a = to_q8(px);  t2a = to_q8(pz);  end
      3'd1: begin r.sec = SEC_2; t1a = to_q8(-py); t2a = to_q8(-pz); end
      3'd5: begin r.sec = SEC_3; t1a = to_q8(py);  t2a = to_q8(px);  end
      3'd4: begin r.sec = SEC_4; t1a = to_q8(-pz); t2a = to_q8(-px); end
      3'd6: begin r.sec = SEC_5; t1a = to_q8(pz);  t2a = to_q8(py);  end
      3'd2: begin r.sec = SEC_6; t1a = to_q8(-px); t2a = to_q8(-py); end
      default: r.sec = SEC_ZERO;
    endcase
    pq = longint'(m_period) << 8;
    if (t1a + t2a > pq) begin
      t1a = t1a * pq / (t1a + t2a);
      t2a = pq - t1a;
      t0 = 0;
      r.scl = 1'b1;
    end else begin
      t0 = pq - t1a - t2a;
    end
    t0 = t0 >>> 1;
    t1 = t0 + t1a;
    t2 = t1 + t2a;
    t0 = t0 >>> 8;
    t1 = t1 >>> 8;
    t2 = t2 >>> 8;
    case (r.sec)
      SEC_1: begin r.cu = t2[15:0]; r.cv = t1[15:0]; r.cw = t0[15:0]; end
      SEC_2: begin r.cu = t1[15:0]; r.cv = t2[15:0]; r.cw = t0[15:0]; end
      SEC_3: begin r.cu = t0[15:0]; r.cv = t2[15:0]; r.cw = t1[15:0]; end
      SEC_4: begin r.cu = t0[15:0]; r.cv = t1[15:0]; r.cw = t2[15:0]; end
      SEC_5: begin r.cu = t1[15:0]; r.cv = t0[15:0]; r.cw = t2[15:0]; end
      SEC_6: begin r.cu = t2[15:0]; r.cv = t0[15:0]; r.cw = t1[15:0]; end
      default: begin r.cu = t0[15:0]; r.cv = t0[15:0]; r.cw = t0[15:0]; end
    endcase
    case (r.sec)
      SEC_1, SEC_6: ref_ph = r.cu;
      SEC_2, SEC_3: ref_ph = r.cv;
      SEC_4, SEC_5: ref_ph = r.cw;
      default: ref_ph = m_period >> 1;
    endcase
    dn = longint'(m_dead) + m_noise;
    if (ref_ph > dn) begin
      r.bnd = BAND_LOW;
      sp = sub_floor(ref_ph, m_sample);
    end else if (dn + m_sample > 2 * ref_ph) begin
      r.bnd = BAND_HIGH;
      sp = sub_floor(ref_ph, dn);
    end else begin
      r.bnd = BAND_MED;
      sp = sub_floor(ref_ph, m_sample);
    end
    r.sp = sp[15:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  // Receiver: check taken beats; alternate random-length ready and stall runs.
  always @(posedge clk) begin
    pwm_result_t w;
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        w = pending_q.pop_front();
        if (compare_u !== w.cu) report_mismatch("compare_u", compare_u, w.cu);
        if (compare_v !== w.cv) report_mismatch("compare_v", compare_v, w.cv);
        if (compare_w !== w.cw) report_mismatch("compare_w", compare_w, w.cw);
        if (sector !== w.sec) report_mismatch("sector", sector, w.sec);
        if (sample_point !== w.sp) report_mismatch("sample_point", sample_point, w.sp);
        if (band !== w.bnd) report_mismatch("band", band, w.bnd);
        if (scaled !== w.scl) report_mismatch("scaled", scaled, w.scl);
        if (w.sec <= SEC_6) sector_seen[w.sec]++;
        if (w.bnd <= BAND_HIGH) band_seen[w.bnd]++;
        if (w.scl) scaled_seen++;
      end
    end
    if (ready_run == 0) begin
      ready_now = ~ready_now;
      ready_run = ready_now ? $urandom_range(1, 40) : $urandom_range(1, 6);
    end else begin
      ready_run--;
    end
    out_ready <= ready_now;
  end

  task automatic send_beat(logic signed [15:0] a, logic signed [15:0] b, logic exact,
                           pwm_result_t want);
    in_valid <= 1'b1;
    volt_alpha <= a;
    volt_beta <= b;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(exact ? want : predict_pwm(a, b));
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_pipe();
    idle_gap(1);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (35) @(posedge clk);
  endtask

  task automatic load_settings(logic [23:0] g, logic [15:0] p, logic [15:0] s,
                               logic [15:0] d, logic [15:0] n);
    logic [CfgIdxW-1:0] idx[6];
    logic [CfgDataW-1:0] val[6];
    drain_pipe();
    idx = '{REG_GAIN, REG_PERIOD, REG_SAMPLE, REG_DEAD, REG_NOISE, REG_SPARE};
    val = '{g, {8'hA5, p}, {8'h5A, s}, {8'hFF, d}, {8'h3C, n}, 24'($urandom)};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    m_gain = g;
    m_period = p;
    m_sample = s;
    m_dead = d;
    m_noise = n;
    @(posedge clk);
  endtask

  // Random voltages across all magnitudes.
  function automatic logic signed [15:0] rand_volt();
    logic signed [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 3))
      0: return v;
      1: return v >>> $urandom_range(4, 15);
      2: return 16'((v >>> $urandom_range(8, 15)) * 3);
      default: return ($urandom_range(0, 5) == 0) ? 16'sd0 : v >>> $urandom_range(0, 15);
    endcase
  endfunction

  task automatic run_random(int n, bit pause_once);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        idle_gap($urandom_range(0, 5));
        burst = $urandom_range(1, 24);
      end
      if (pause_once && i == n / 2) drain_pipe();
      send_beat(rand_volt(), rand_volt(), 1'b0, '0);
      burst--;
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_GAIN;
    cfg_data <= '0;
    in_valid <= 1'b0;
    volt_alpha <= '0;
    volt_beta <= '0;
    m_gain = GAIN_RST;
    m_period = PERIOD_RST;
    m_sample = SAMPLE_RST;
    m_dead = DEAD_RST;
    m_noise = NOISE_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (vectors[i]) begin
      send_beat(vectors[i].a, vectors[i].b, vectors[i].exact, vectors[i].want);
      if (i % 4 == 3) idle_gap($urandom_range(1, 3));
    end
    run_random(250, 1'b1);

    load_settings(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    run_random(150, 1'b0);
    load_settings(24'h000000, 16'd1, 16'd0, 16'hFFFF, 16'hFFFF);
    run_random(120, 1'b0);
    // A short period and wide windows push most beats into the high band.
    load_settings(24'd2000, 16'd200, 16'd150, 16'd60, 16'd50);
    run_random(220, 1'b0);
    load_settings(24'd40, 16'd1000, 16'd30, 16'd100, 16'd120);
    run_random(220, 1'b0);
    load_settings(24'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom),
                  16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)));
    run_random(170, 1'b0);

    drain_pipe();
    $display("Run covered %0d beats, %0d scaled; sectors 0..6: %0d %0d %0d %0d %0d %0d %0d",
             beats_out, scaled_seen, sector_seen[0], sector_seen[1], sector_seen[2],
             sector_seen[3], sector_seen[4], sector_seen[5], sector_seen[6]);
    $display("Bands low/medium/high: %0d %0d %0d; mismatches: %0d",
             band_seen[0], band_seen[1], band_seen[2], errors);
    if (errors == 0) begin
      $display("** svpwm_compare_and_sample_point_core: PASSED **");
    end else begin
      $display("** svpwm_compare_and_sample_point_core: FAILED **");
    end
    $finish;
  end

endmodule
